// ----- src/xmt_pkg.sv -----
`timescale 1ns / 1ps

package xmt_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  typedef enum logic [3:0] {
    M_IDLE, M_LT, M_BANG, M_BANG_DASH, M_CD_PREFIX, M_PROLOG, M_DOCTYPE, M_COMMENT,
    M_CDATA, M_TEXT, M_OPEN_NAME, M_OPEN_ATTR, M_OPEN_SLASH, M_OPEN_SKIP,
    M_CLOSE_NAME, M_CLOSE_SKIP
  } mode_t;

  typedef enum logic [2:0] {
    T_PROLOG, T_DOCTYPE, T_OPEN, T_CLOSE, T_SELF, T_TEXT, T_COMMENT, T_CDATA
  } tok_t;

  // which fixed markup string a prefix burst is read from
  typedef enum logic [1:0] {
    PFX_COMMENT, PFX_CDATA, PFX_PROLOG
  } pfx_sel_t;

  // one request from front to back: prefix bytes, optional byte, optional token end
  typedef struct packed {
    pfx_sel_t   pre_sel;
    logic [3:0] pre_len;
    logic       has_byte;
    logic [7:0] data;
    logic       has_end;
    tok_t       end_type;
    logic       unterm;
  } cmd_t;

  // "[CDATA[" indexed from 0
  function automatic logic [7:0] cdata_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = CH_LBRK;
      3'd1: c = 8'h43;
      3'd2: c = 8'h44;
      3'd3: c = 8'h41;
      3'd4: c = 8'h54;
      3'd5: c = 8'h41;
      3'd6: c = CH_LBRK;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input pfx_sel_t sel, input logic [3:0] i);
    logic [7:0] c;
    c = 8'h00;
    if (i == 4'd0) begin
      c = CH_LT;
    end else if (i == 4'd1) begin
      c = (sel == PFX_PROLOG) ? CH_QUEST : CH_BANG;
    end else if (sel == PFX_COMMENT) begin
      c = CH_DASH;
    end else if (sel == PFX_CDATA && i <= 4'd8) begin
      c = cdata_char(3'(i - 4'd2));
    end
    return c;
  endfunction

endpackage

// ----- src/xmt_front.sv -----
`timescale 1ns / 1ps

module xmt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             op,
  input  logic [7:0]       data_byte,
  input  logic             q_full,
  output logic             q_push,
  output xmt_pkg::cmd_t    q_cmd
);

  xmt_pkg::mode_t   mode, mode_next;
  logic [2:0]       pcnt, pcnt_next;
  logic [1:0]       tcnt, tcnt_next;
  logic             accept;
  logic             is_ws;
  logic             go_doctype;
  xmt_pkg::pfx_sel_t flush_sel;
  logic [3:0]       flush_len;
  logic [7:0]       term_ch;
  logic             term_hit;
  logic [1:0]       term_cnt;
  xmt_pkg::cmd_t    cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_cmd    = cmd;
  assign q_push   = accept && (cmd.pre_len != 4'd0 || cmd.has_byte || cmd.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= xmt_pkg::M_IDLE;
      pcnt <= '0;
      tcnt <= '0;
    end else if (accept) begin
      mode <= mode_next;
      pcnt <= pcnt_next;
      tcnt <= tcnt_next;
    end
  end

  always_comb begin
    is_ws = data_byte inside {xmt_pkg::CH_SPACE, [8'd9:8'd13]};

    // held "<!" prefix and what has matched after it
    if (mode == xmt_pkg::M_BANG_DASH) begin
      flush_sel = xmt_pkg::PFX_COMMENT;
      flush_len = 4'd3;
    end else if (mode == xmt_pkg::M_CD_PREFIX) begin
      flush_sel = xmt_pkg::PFX_CDATA;
      flush_len = 4'd2 + ((pcnt > 3'd6) ? 4'd6 : {1'b0, pcnt});
    end else begin
      flush_sel = xmt_pkg::PFX_CDATA;
      flush_len = 4'd2;
    end

    // "--" / "]]" followed by '>'
    term_ch = (mode == xmt_pkg::M_COMMENT) ? xmt_pkg::CH_DASH : xmt_pkg::CH_RBRK;
    if (tcnt >= 2'd2) begin
      term_hit = (data_byte == xmt_pkg::CH_GT);
      term_cnt = (data_byte == term_ch) ? 2'd2 : 2'd0;
    end else begin
      term_hit = 1'b0;
      term_cnt = (data_byte == term_ch) ? tcnt + 2'd1 : 2'd0;
    end

    mode_next  = mode;
    pcnt_next  = pcnt;
    tcnt_next  = tcnt;
    go_doctype = 1'b0;
    cmd        = '0;

    if (op) begin
      cmd.has_end = (mode != xmt_pkg::M_IDLE);
      cmd.unterm  = (mode != xmt_pkg::M_TEXT);
      case (mode)
        xmt_pkg::M_TEXT:    cmd.end_type = xmt_pkg::T_TEXT;
        xmt_pkg::M_BANG, xmt_pkg::M_BANG_DASH, xmt_pkg::M_CD_PREFIX: begin
          cmd.pre_sel  = flush_sel;
          cmd.pre_len  = flush_len;
          cmd.end_type = xmt_pkg::T_DOCTYPE;
        end
        xmt_pkg::M_PROLOG:  cmd.end_type = xmt_pkg::T_PROLOG;
        xmt_pkg::M_DOCTYPE: cmd.end_type = xmt_pkg::T_DOCTYPE;
        xmt_pkg::M_COMMENT: cmd.end_type = xmt_pkg::T_COMMENT;
        xmt_pkg::M_CDATA:   cmd.end_type = xmt_pkg::T_CDATA;
        xmt_pkg::M_CLOSE_NAME, xmt_pkg::M_CLOSE_SKIP: cmd.end_type = xmt_pkg::T_CLOSE;
        default:            cmd.end_type = xmt_pkg::T_OPEN;
      endcase
      mode_next = xmt_pkg::M_IDLE;
      pcnt_next = '0;
      tcnt_next = '0;
    end else begin
      case (mode)
        xmt_pkg::M_IDLE: begin
          if (data_byte == xmt_pkg::CH_LT) begin
            mode_next = xmt_pkg::M_LT;
          end else if (!is_ws) begin
            mode_next    = xmt_pkg::M_TEXT;
            cmd.has_byte = 1'b1;
            cmd.data     = data_byte;
          end
        end
        xmt_pkg::M_TEXT: begin
          if (data_byte == xmt_pkg::CH_LT) begin
            cmd.has_end  = 1'b1;
            cmd.end_type = xmt_pkg::T_TEXT;
            mode_next    = xmt_pkg::M_LT;
            pcnt_next    = '0;
            tcnt_next    = '0;
          end else begin
            cmd.has_byte = 1'b1;
            cmd.data     = data_byte;
          end
        end
        xmt_pkg::M_LT: begin
          case (data_byte)
            xmt_pkg::CH_QUEST: begin
              cmd.pre_sel = xmt_pkg::PFX_PROLOG;
              cmd.pre_len = 4'd2;
              mode_next   = xmt_pkg::M_PROLOG;
              tcnt_next   = 2'd1;
            end
            xmt_pkg::CH_BANG:  mode_next = xmt_pkg::M_BANG;
            xmt_pkg::CH_SLASH: mode_next = xmt_pkg::M_CLOSE_NAME;
            xmt_pkg::CH_GT: begin
              cmd.has_end  = 1'b1;
              cmd.end_type = xmt_pkg::T_OPEN;
              mode_next    = xmt_pkg::M_IDLE;
            end
            xmt_pkg::CH_SPACE: mode_next = xmt_pkg::M_OPEN_ATTR;
            default: begin
              cmd.has_byte = 1'b1;
              cmd.data     = data_byte;
              mode_next    = xmt_pkg::M_OPEN_NAME;
            end
          endcase
        end
        xmt_pkg::M_BANG: begin
          if (data_byte == xmt_pkg::CH_DASH) begin
            mode_next = xmt_pkg::M_BANG_DASH;
          end else if (data_byte == xmt_pkg::CH_LBRK) begin
            mode_next = xmt_pkg::M_CD_PREFIX;
            pcnt_next = 3'd1;
          end else begin
            go_doctype = 1'b1;
          end
        end
        xmt_pkg::M_BANG_DASH: begin
          if (data_byte == xmt_pkg::CH_DASH) begin
            cmd.pre_sel = xmt_pkg::PFX_COMMENT;
            cmd.pre_len = 4'd4;
            mode_next   = xmt_pkg::M_COMMENT;
            tcnt_next   = 2'd2;
          end else begin
            go_doctype = 1'b1;
          end
        end
        xmt_pkg::M_CD_PREFIX: begin
          if (pcnt >= 3'd1 && pcnt <= 3'd6 && data_byte == xmt_pkg::cdata_char(pcnt)) begin
            if (pcnt == 3'd6) begin
              cmd.pre_sel = xmt_pkg::PFX_CDATA;
              cmd.pre_len = 4'd9;
              mode_next   = xmt_pkg::M_CDATA;
              pcnt_next   = '0;
              tcnt_next   = '0;
            end else begin
              pcnt_next = pcnt + 3'd1;
            end
          end else begin
            go_doctype = 1'b1;
          end
        end
        xmt_pkg::M_PROLOG: begin
          cmd.has_byte = 1'b1;
          cmd.data     = data_byte;
          if (tcnt == 2'd1 && data_byte == xmt_pkg::CH_GT) begin
            cmd.has_end  = 1'b1;
            cmd.end_type = xmt_pkg::T_PROLOG;
            mode_next    = xmt_pkg::M_IDLE;
            pcnt_next    = '0;
            tcnt_next    = '0;
          end else begin
            tcnt_next = (data_byte == xmt_pkg::CH_QUEST) ? 2'd1 : 2'd0;
          end
        end
        xmt_pkg::M_DOCTYPE: begin
          cmd.has_byte = 1'b1;
          cmd.data     = data_byte;
          if (data_byte == xmt_pkg::CH_GT) begin
            cmd.has_end  = 1'b1;
            cmd.end_type = xmt_pkg::T_DOCTYPE;
            mode_next    = xmt_pkg::M_IDLE;
            pcnt_next    = '0;
            tcnt_next    = '0;
          end
        end
        xmt_pkg::M_COMMENT, xmt_pkg::M_CDATA: begin
          cmd.has_byte = 1'b1;
          cmd.data     = data_byte;
          if (term_hit) begin
            cmd.has_end  = 1'b1;
            cmd.end_type = (mode == xmt_pkg::M_COMMENT) ? xmt_pkg::T_COMMENT
                                                        : xmt_pkg::T_CDATA;
            mode_next    = xmt_pkg::M_IDLE;
            pcnt_next    = '0;
            tcnt_next    = '0;
          end else begin
            tcnt_next = term_cnt;
          end
        end
        xmt_pkg::M_OPEN_NAME, xmt_pkg::M_OPEN_ATTR: begin
          if (data_byte == xmt_pkg::CH_GT) begin
            cmd.has_end  = 1'b1;
            cmd.end_type = xmt_pkg::T_OPEN;
            mode_next    = xmt_pkg::M_IDLE;
          end else if (data_byte == xmt_pkg::CH_SLASH) begin
            mode_next = xmt_pkg::M_OPEN_SLASH;
          end else if (mode == xmt_pkg::M_OPEN_NAME) begin
            if (data_byte == xmt_pkg::CH_SPACE) begin
              mode_next = xmt_pkg::M_OPEN_ATTR;
            end else begin
              cmd.has_byte = 1'b1;
              cmd.data     = data_byte;
            end
          end
        end
        xmt_pkg::M_OPEN_SLASH: begin
          if (data_byte == xmt_pkg::CH_GT) begin
            cmd.has_end  = 1'b1;
            cmd.end_type = xmt_pkg::T_SELF;
            mode_next    = xmt_pkg::M_IDLE;
          end else begin
            mode_next = xmt_pkg::M_OPEN_SKIP;
          end
        end
        xmt_pkg::M_OPEN_SKIP: begin
          if (data_byte == xmt_pkg::CH_GT) begin
            cmd.has_end  = 1'b1;
            cmd.end_type = xmt_pkg::T_OPEN;
            mode_next    = xmt_pkg::M_IDLE;
          end
        end
        xmt_pkg::M_CLOSE_NAME: begin
          if (data_byte == xmt_pkg::CH_GT) begin
            cmd.has_end  = 1'b1;
            cmd.end_type = xmt_pkg::T_CLOSE;
            mode_next    = xmt_pkg::M_IDLE;
          end else if (data_byte == xmt_pkg::CH_SPACE || data_byte == xmt_pkg::CH_SLASH) begin
            mode_next = xmt_pkg::M_CLOSE_SKIP;
          end else begin
            cmd.has_byte = 1'b1;
            cmd.data     = data_byte;
          end
        end
        xmt_pkg::M_CLOSE_SKIP: begin
          if (data_byte == xmt_pkg::CH_GT) begin
            cmd.has_end  = 1'b1;
            cmd.end_type = xmt_pkg::T_CLOSE;
            mode_next    = xmt_pkg::M_IDLE;
          end
        end
        default: begin
          mode_next = xmt_pkg::M_IDLE;
          pcnt_next = '0;
          tcnt_next = '0;
        end
      endcase

      // "<!" not followed by a comment or CDATA opener
      if (go_doctype) begin
        cmd.pre_sel  = flush_sel;
        cmd.pre_len  = flush_len;
        cmd.has_byte = 1'b1;
        cmd.data     = data_byte;
        mode_next    = xmt_pkg::M_DOCTYPE;
        pcnt_next    = '0;
        if (data_byte == xmt_pkg::CH_GT) begin
          cmd.has_end  = 1'b1;
          cmd.end_type = xmt_pkg::T_DOCTYPE;
          mode_next    = xmt_pkg::M_IDLE;
          tcnt_next    = '0;
        end
      end
    end
  end

endmodule

// ----- src/xmt_queue.sv -----
`timescale 1ns / 1ps

module xmt_queue #(
  parameter int DEPTH = xmt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xmt_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output xmt_pkg::cmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xmt_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- src/xmt_back.sv -----
`timescale 1ns / 1ps

module xmt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  xmt_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          kind,
  output logic [7:0]    content_byte,
  output logic [2:0]    token_type,
  output logic          unterminated,
  output logic          last_of_run
);

  logic [3:0] idx;
  logic [3:0] total;
  logic       is_last;
  logic       load;
  logic       r_kind;
  logic [7:0] r_byte;
  logic [2:0] r_type;
  logic       r_unterm;

  assign total   = q_head.pre_len + {3'b0, q_head.has_byte} + {3'b0, q_head.has_end};
  assign is_last = (idx == total - 4'd1);
  assign load    = !out_valid || !out_stall;
  assign q_pop   = load && !q_empty && is_last;

  // pick result number idx out of the head request
  always_comb begin
    r_kind   = 1'b0;
    r_byte   = 8'h00;
    r_type   = 3'd0;
    r_unterm = 1'b0;
    if (idx < q_head.pre_len) begin
      r_byte = xmt_pkg::prefix_char(q_head.pre_sel, idx);
    end else if (idx == q_head.pre_len && q_head.has_byte) begin
      r_byte = q_head.data;
    end else begin
      r_kind   = 1'b1;
      r_type   = q_head.end_type;
      r_unterm = q_head.unterm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= is_last ? 4'd0 : idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      kind         <= r_kind;
      content_byte <= r_byte;
      token_type   <= r_type;
      unterminated <= r_unterm;
      last_of_run  <= is_last;
    end
  end

endmodule

// ----- src/xml_markup_tokenizer.sv -----
`timescale 1ns / 1ps

// Byte-serial XML tokenizer. One document byte (or an end-of-document mark) is
// taken per cycle while in_stall is low; the front decoder updates the parse
// state in that cycle and queues one request per byte that yields anything. The
// back end plays requests out as results at one per cycle while out_stall is low,
// from a registered output. The first result of a byte passes through the queue
// and then the output register. Bytes that yield at most one result each stream
// through at one per cycle while neither side stalls. A byte that releases a
// held "<!..." prefix yields up to ten results and occupies the output until the
// last of them is loaded. That request keeps its queue slot until its last
// result is loaded, so QUEUE_DEPTH - 1 further requests can wait behind it.
// in_stall is raised whenever the queue is full, even for bytes that yield nothing.
module xml_markup_tokenizer #(
  parameter int QUEUE_DEPTH = xmt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] content_byte,
  output logic [2:0] token_type,
  output logic       unterminated,
  output logic       last_of_run
);

  logic          q_full, q_push, q_empty, q_pop;
  xmt_pkg::cmd_t q_in, q_head;

  xmt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  xmt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (q_head)
  );

  xmt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .content_byte (content_byte),
    .token_type   (token_type),
    .unterminated (unterminated),
    .last_of_run  (last_of_run)
  );

endmodule

// ----- src/xmt_checker.sv -----
`timescale 1ns / 1ps

module xmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       op,
  input logic [7:0] data_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [7:0] content_byte,
  input logic [2:0] token_type,
  input logic       unterminated,
  input logic       last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(content_byte)
      && $stable(token_type) && $stable(unterminated) && $stable(last_of_run))
    else $error("stalled result changed");

  // content results carry no end info, ends carry no byte
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind ? (content_byte == 8'h00)
                        : (token_type == 3'd0 && !unterminated)))
    else $error("result fields inconsistent with kind");

  // a forced end is always the final result of its request
  a_unterm_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind && unterminated |-> last_of_run)
    else $error("unterminated end not last of run");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind xml_markup_tokenizer xmt_checker u_chk (.*);
